// ===== src/pbic_pkg.sv =====
package pbic_pkg;

   // Fixed field widths of the bar and result transactions.
   localparam int TIME_BITS    = 32;
   localparam int PORT_PRICE_BITS = 32;
   localparam int VOLUME_BITS  = 48;
   localparam int MASK_BITS    = 5;
   localparam int JUMP_BITS    = 10;
   localparam int GAP_BITS     = 11;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_JUMP_LIMIT   = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_EXPECTED_GAP = CSR_INDEX_BITS'(1);

   localparam logic [JUMP_BITS-1:0] JUMP_LIMIT_RESET = JUMP_BITS'(100);
   localparam logic [GAP_BITS-1:0]  GAP_RESET        = GAP_BITS'(1);

   // The jump limit is expressed in thousandths of the previous close.
   localparam int JUMP_SCALE = 1000;

   // Bit positions in the violation mask.
   localparam int RULE_ZERO  = 0;
   localparam int RULE_GAP   = 1;
   localparam int RULE_RANGE = 2;
   localparam int RULE_JUMP  = 3;
   localparam int RULE_FLAT  = 4;

   typedef struct packed {
      logic [JUMP_BITS-1:0] jump_limit_permille;
      logic [GAP_BITS-1:0]  expected_gap_minutes;
   } cfg_type;

endpackage

// ===== src/pbic_req_if.sv =====
interface pbic_req_if
   import pbic_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       first_of_series;
   logic [TIME_BITS-1:0]       time_minutes;
   logic [PORT_PRICE_BITS-1:0] open_price;
   logic [PORT_PRICE_BITS-1:0] high_price;
   logic [PORT_PRICE_BITS-1:0] low_price;
   logic [PORT_PRICE_BITS-1:0] close_price;
   logic [VOLUME_BITS-1:0]     traded_volume;

   modport source (
      output valid, first_of_series, time_minutes, open_price, high_price,
             low_price, close_price, traded_volume,
      input  ready
   );

   modport sink (
      input  valid, first_of_series, time_minutes, open_price, high_price,
             low_price, close_price, traded_volume,
      output ready
   );
endinterface

// ===== src/pbic_rsp_if.sv =====
interface pbic_rsp_if
   import pbic_pkg::*;
();
   logic                 valid;
   logic                 ready;
   logic [MASK_BITS-1:0] violation_mask;
   logic                 series_ok;

   modport source (
      output valid, violation_mask, series_ok,
      input  ready
   );

   modport sink (
      input  valid, violation_mask, series_ok,
      output ready
   );
endinterface

// ===== src/pbic_csr_if.sv =====
interface pbic_csr_if
   import pbic_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  wdata;

   modport source (
      output valid, index, wdata,
      input  ready
   );

   modport sink (
      input  valid, index, wdata,
      output ready
   );
endinterface

// ===== src/price_bar_integrity_checker.sv =====
// Price bar integrity checker.
//
// The req_ch channel carries one price bar per transaction: a first-of-series
// bit, a timestamp in minutes, open, high, low and close prices in units of
// 0.0001 and the traded volume. For every bar the rsp_ch channel returns one
// transaction with a five-bit mask of broken rules and a sticky series_ok flag
// that stays high until a bar of the current series breaks any rule.
// The csr_ch channel writes the jump limit (index 0) and the expected gap
// (index 1); it is always ready and should only be used while no bar is in
// flight.
//
// A bar accepted on req_ch is captured in an input register, checked by one
// level of compare and multiply logic and moved into the result register,
// which drives rsp_ch, once that register is empty or is being emptied. One
// bar is accepted per cycle while rsp_ch keeps up. When the receiver stalls,
// the result register holds and the input register takes one more bar;
// after that req_ch.ready drops until the result moves.
// A synchronous reset empties both registers, clears the history, sets the
// series flag and restores the register defaults (limit 100, gap 1).
module price_bar_integrity_checker
   import pbic_pkg::*;
#(
   parameter int unsigned PRICE_BITS = 32
) (
   input logic        clock,
   input logic        reset,
   pbic_req_if.sink   req_ch,
   pbic_rsp_if.source rsp_ch,
   pbic_csr_if.sink   csr_ch
);

   // Input register: one bar waiting to be checked.
   logic                   in_valid_ff, in_valid_in;
   logic                   in_first_ff, in_first_in;
   logic [TIME_BITS-1:0]   in_time_ff, in_time_in;
   logic [PRICE_BITS-1:0]  in_open_ff, in_open_in;
   logic [PRICE_BITS-1:0]  in_high_ff, in_high_in;
   logic [PRICE_BITS-1:0]  in_low_ff, in_low_in;
   logic [PRICE_BITS-1:0]  in_close_ff, in_close_in;
   logic [VOLUME_BITS-1:0] in_volume_ff, in_volume_in;

   // Result register.
   logic                   out_valid_ff, out_valid_in;
   logic [MASK_BITS-1:0]   out_mask_ff, out_mask_in;
   logic                   out_ok_ff, out_ok_in;

   // Series history, updated as each bar is checked.
   logic [TIME_BITS-1:0]   last_time_ff, last_time_in;
   logic [PRICE_BITS-1:0]  last_close_ff, last_close_in;
   logic                   have_previous_ff, have_previous_in;
   logic                   all_good_ff, all_good_in;

   cfg_type                cfg_ff, cfg_in;

   logic                   req_accept;
   logic                   advance;
   logic                   history_valid;
   logic [MASK_BITS-1:0]   mask;

   // The checked bar moves into the result register when that register is
   // empty or is being emptied in this cycle.
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign req_accept    = req_ch.valid && req_ch.ready;
   assign csr_ch.ready  = 1'b1;

   // A first-of-series bar sees no previous bar.
   assign history_valid = have_previous_ff && !in_first_ff;

   pbic_rules #(
      .PRICE_BITS (PRICE_BITS)
   ) u_rules (
      .cfg            (cfg_ff),
      .have_previous  (history_valid),
      .last_time      (last_time_ff),
      .last_close     (last_close_ff),
      .time_minutes   (in_time_ff),
      .open_price     (in_open_ff),
      .high_price     (in_high_ff),
      .low_price      (in_low_ff),
      .close_price    (in_close_ff),
      .traded_volume  (in_volume_ff),
      .violation_mask (mask)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_first_in  = in_first_ff;
      in_time_in   = in_time_ff;
      in_open_in   = in_open_ff;
      in_high_in   = in_high_ff;
      in_low_in    = in_low_ff;
      in_close_in  = in_close_ff;
      in_volume_in = in_volume_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_accept) begin
         in_valid_in  = 1'b1;
         in_first_in  = req_ch.first_of_series;
         in_time_in   = req_ch.time_minutes;
         // Only the low PRICE_BITS bits of a price take part in the checks.
         in_open_in   = PRICE_BITS'(req_ch.open_price);
         in_high_in   = PRICE_BITS'(req_ch.high_price);
         in_low_in    = PRICE_BITS'(req_ch.low_price);
         in_close_in  = PRICE_BITS'(req_ch.close_price);
         in_volume_in = req_ch.traded_volume;
      end
   end

   always_comb begin
      out_valid_in     = out_valid_ff;
      out_mask_in      = out_mask_ff;
      out_ok_in        = out_ok_ff;
      last_time_in     = last_time_ff;
      last_close_in    = last_close_ff;
      have_previous_in = have_previous_ff;
      all_good_in      = all_good_ff;
      if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         all_good_in      = (in_first_ff || all_good_ff) && (mask == '0);
         out_valid_in     = 1'b1;
         out_mask_in      = mask;
         out_ok_in        = all_good_in;
         last_time_in     = in_time_ff;
         last_close_in    = in_close_ff;
         have_previous_in = 1'b1;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         case (csr_ch.index)
            CSR_JUMP_LIMIT: begin
               cfg_in.jump_limit_permille = csr_ch.wdata[JUMP_BITS-1:0];
            end
            CSR_EXPECTED_GAP: begin
               cfg_in.expected_gap_minutes = csr_ch.wdata[GAP_BITS-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         out_valid_ff                <= 1'b0;
         have_previous_ff            <= 1'b0;
         all_good_ff                 <= 1'b1;
         cfg_ff.jump_limit_permille  <= JUMP_LIMIT_RESET;
         cfg_ff.expected_gap_minutes <= GAP_RESET;
      end else begin
         in_valid_ff      <= in_valid_in;
         out_valid_ff     <= out_valid_in;
         have_previous_ff <= have_previous_in;
         all_good_ff      <= all_good_in;
         cfg_ff           <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      in_first_ff   <= in_first_in;
      in_time_ff    <= in_time_in;
      in_open_ff    <= in_open_in;
      in_high_ff    <= in_high_in;
      in_low_ff     <= in_low_in;
      in_close_ff   <= in_close_in;
      in_volume_ff  <= in_volume_in;
      out_mask_ff   <= out_mask_in;
      out_ok_ff     <= out_ok_in;
      last_time_ff  <= last_time_in;
      last_close_ff <= last_close_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.violation_mask = out_mask_ff;
   assign rsp_ch.series_ok      = out_ok_ff;

`ifndef ASSERT_OFF
   // A reported good series can never carry a broken rule.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ok_ff |-> out_mask_ff == '0)
      else $error("series_ok reported with a nonzero violation mask");

   // A bar that cannot move on stays in the input register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("waiting bar lost from the input register");

   // Every checked bar produces a result.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("checked bar did not reach the result register");

   // After a checked bar the history always holds a previous bar.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> have_previous_ff && last_close_ff == $past(in_close_ff))
      else $error("history not updated by a checked bar");

   // Leaving reset finds both pipeline registers empty and the series flag set.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !in_valid_ff && !out_valid_ff && all_good_ff)
      else $error("pipeline state wrong after reset");
`endif

endmodule

// ===== src/pbic_rules.sv =====
module pbic_rules
   import pbic_pkg::*;
#(
   parameter int unsigned PRICE_BITS = 32
) (
   input  cfg_type               cfg,
   input  logic                  have_previous,
   input  logic [TIME_BITS-1:0]  last_time,
   input  logic [PRICE_BITS-1:0] last_close,
   input  logic [TIME_BITS-1:0]  time_minutes,
   input  logic [PRICE_BITS-1:0] open_price,
   input  logic [PRICE_BITS-1:0] high_price,
   input  logic [PRICE_BITS-1:0] low_price,
   input  logic [PRICE_BITS-1:0] close_price,
   input  logic [VOLUME_BITS-1:0] traded_volume,
   output logic [MASK_BITS-1:0]  violation_mask
);

   localparam int PROD_BITS = PRICE_BITS + JUMP_BITS;

   logic [TIME_BITS:0]      expected_time;
   logic [PRICE_BITS-1:0]   jump_diff;
   logic [PROD_BITS-1:0]    diff_scaled;
   logic [PROD_BITS-1:0]    limit_scaled;

   // The sum keeps its carry so that a wrapped timestamp never matches.
   assign expected_time = {1'b0, last_time} + (TIME_BITS + 1)'(cfg.expected_gap_minutes);

   assign jump_diff = (open_price >= last_close) ? (open_price - last_close)
                                                 : (last_close - open_price);

   // Cross-multiplied form of |open - last_close| / last_close > limit / 1000.
   assign diff_scaled  = PROD_BITS'(jump_diff) * PROD_BITS'(JUMP_SCALE);
   assign limit_scaled = PROD_BITS'(cfg.jump_limit_permille) * PROD_BITS'(last_close);

   always_comb begin
      violation_mask = '0;
      violation_mask[RULE_ZERO] = (open_price == '0) || (high_price == '0) ||
                                  (low_price == '0) || (close_price == '0);
      violation_mask[RULE_GAP] = have_previous &&
                                 (expected_time != {1'b0, time_minutes});
      violation_mask[RULE_RANGE] = (high_price < low_price) ||
                                   (open_price > high_price) || (open_price < low_price) ||
                                   (close_price > high_price) || (close_price < low_price);
      violation_mask[RULE_JUMP] = have_previous && (diff_scaled > limit_scaled);
      violation_mask[RULE_FLAT] = (traded_volume != '0) && (open_price == high_price) &&
                                  (high_price == low_price) && (low_price == close_price);
   end

endmodule
